@@ rtl/glyph_shaded_texel_sampler_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the glyph shaded texel sampler
// Implication checks on the clock and the active-low reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_SHADED_TEXEL_SAMPLER_ASSERT_SVH
`define GLYPH_SHADED_TEXEL_SAMPLER_ASSERT_SVH

// same-cycle implication
`define GST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gst_pkg.sv @@
// ----------------------------------------------------------------------------
// gst_pkg
// Codes and constants shared by the texel sampler modules.
// ----------------------------------------------------------------------------
package gst_pkg;

  localparam int CfgWidth    = 7;
  localparam int ColourWidth = 8;
  localparam int AttrWidth   = 12;
  localparam int ShadeWidth  = 2;
  localparam int ReqColWidth = 7;
  localparam int CfgReset    = 32;

  // shade thresholds: d < 0.30 and d < 0.45 as exact integer compares
  localparam int ShadeMulA = 10;
  localparam int ShadeRefA = 3;
  localparam int ShadeMulB = 20;
  localparam int ShadeRefB = 9;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } reg_e;

  typedef enum logic [ShadeWidth-1:0] {
    SHADE_SOLID = 2'd0,
    SHADE_3Q    = 2'd1,
    SHADE_HALF  = 2'd2
  } shade_e;

endpackage

@@ rtl/gst_coord.sv @@
// ----------------------------------------------------------------------------
// gst_coord
// Two stages: clamp and scale coordinates, then texel, quadrant and neighbours.
// ----------------------------------------------------------------------------
module gst_coord #(
  parameter int MAX_WIDTH       = 64,
  parameter int MAX_HEIGHT      = 64,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                    eff_w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]                   eff_h_i,
  input  logic                                              valid_i,
  input  logic                                              opcode_i,
  input  logic [COORD_FRAC_BITS:0]                          x_coord_i,
  input  logic [COORD_FRAC_BITS:0]                          y_coord_i,
  input  logic [gst_pkg::ReqColWidth-1:0]                   texel_col_i,
  input  logic [gst_pkg::ReqColWidth-1:0]                   texel_row_i,
  input  logic [gst_pkg::ColourWidth-1:0]                   write_colour_i,
  output logic                                              valid_o,
  output logic                                              opcode_o,
  output logic                                              wok_o,
  output logic [((MAX_WIDTH>1)?$clog2(MAX_WIDTH):1)-1:0]    ix_o,
  output logic [((MAX_HEIGHT>1)?$clog2(MAX_HEIGHT):1)-1:0]  iy_o,
  output logic [((MAX_WIDTH>1)?$clog2(MAX_WIDTH):1)-1:0]    n1c_o,
  output logic [((MAX_HEIGHT>1)?$clog2(MAX_HEIGHT):1)-1:0]  n1r_o,
  output logic [((MAX_WIDTH>1)?$clog2(MAX_WIDTH):1)-1:0]    n2c_o,
  output logic [((MAX_HEIGHT>1)?$clog2(MAX_HEIGHT):1)-1:0]  n2r_o,
  output logic [COORD_FRAC_BITS-1:0]                        d1_o,
  output logic [COORD_FRAC_BITS-1:0]                        d2_o,
  output logic [gst_pkg::ColourWidth-1:0]                   colour_o
);
  import gst_pkg::*;

  localparam int FB  = COORD_FRAC_BITS;
  localparam int CB  = FB + 1;
  localparam int EW  = $clog2(MAX_WIDTH+1);
  localparam int EH  = $clog2(MAX_HEIGHT+1);
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int FXW = CB + EW;
  localparam int FYW = CB + EH;
  localparam logic [CB-1:0] One  = CB'(1) << FB;
  localparam logic [FB-1:0] Half = FB'(1) << (FB - 1);

  logic [CB-1:0]          xc, yc;
  logic [FXW-1:0]         fx_d, fx_q;
  logic [FYW-1:0]         fy_d, fy_q;
  logic                   v1_q, op1_q;
  logic [ReqColWidth-1:0] col1_q, row1_q;
  logic [ColourWidth-1:0] colour1_q;

  assign xc   = (x_coord_i > One) ? One : x_coord_i;
  assign yc   = (y_coord_i > One) ? One : y_coord_i;
  assign fx_d = FXW'(xc) * FXW'(eff_w_i);
  assign fy_d = FYW'(yc) * FYW'(eff_h_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_q      <= fx_d;
      fy_q      <= fy_d;
      op1_q     <= opcode_i;
      col1_q    <= texel_col_i;
      row1_q    <= texel_row_i;
      colour1_q <= write_colour_i;
    end
  end

  logic [EW:0]   ipx;
  logic [EH:0]   ipy;
  logic [CW-1:0] ix, right, left;
  logic [RW-1:0] iy, down, up;
  logic [FB-1:0] dx, dy;
  logic [CB-1:0] one_dx, one_dy;
  logic [CW-1:0] n1c_d, n2c_d, ix_d;
  logic [RW-1:0] n1r_d, n2r_d, iy_d;
  logic [FB-1:0] d1_d, d2_d;
  logic          wok_d;

  assign ipx    = fx_q[FXW-1:FB];
  assign ipy    = fy_q[FYW-1:FB];
  assign ix     = (ipx == (EW+1)'(eff_w_i)) ? '0 : CW'(ipx);
  assign iy     = (ipy == (EH+1)'(eff_h_i)) ? '0 : RW'(ipy);
  assign dx     = fx_q[FB-1:0];
  assign dy     = fy_q[FB-1:0];
  assign one_dx = One - CB'(dx);
  assign one_dy = One - CB'(dy);
  assign right  = (CW'(ix + CW'(1)) == CW'(eff_w_i)) || (EW'(ix) + EW'(1) == eff_w_i)
                  ? '0 : CW'(ix + CW'(1));
  assign left   = (ix == '0) ? CW'(eff_w_i - EW'(1)) : CW'(ix - CW'(1));
  assign down   = ((EH'(iy) + EH'(1)) == eff_h_i) ? '0 : RW'(iy + RW'(1));
  assign up     = (iy == '0) ? RW'(eff_h_i - EH'(1)) : RW'(iy - RW'(1));

  always_comb begin
    if (dx >= Half && dy >= Half) begin
      if (dx > dy) begin
        n1c_d = right; n1r_d = iy;   d1_d = dx - Half;
        n2c_d = ix;    n2r_d = down; d2_d = dy - Half;
      end else begin
        n1c_d = ix;    n1r_d = down; d1_d = dy - Half;
        n2c_d = right; n2r_d = iy;   d2_d = dx - Half;
      end
    end else if (dx >= Half && dy <= Half) begin
      if (one_dx < CB'(dy)) begin
        n1c_d = right; n1r_d = iy;   d1_d = dx - Half;
        n2c_d = ix;    n2r_d = up;   d2_d = Half - dy;
      end else begin
        n1c_d = ix;    n1r_d = up;   d1_d = Half - dy;
        n2c_d = right; n2r_d = iy;   d2_d = dx - Half;
      end
    end else if (dx <= Half && dy >= Half) begin
      if (CB'(dx) < one_dy) begin
        n1c_d = left;  n1r_d = iy;   d1_d = Half - dx;
        n2c_d = ix;    n2r_d = down; d2_d = dy - Half;
      end else begin
        n1c_d = ix;    n1r_d = down; d1_d = dy - Half;
        n2c_d = left;  n2r_d = iy;   d2_d = Half - dx;
      end
    end else begin
      if (dx < dy) begin
        n1c_d = left;  n1r_d = iy;   d1_d = Half - dx;
        n2c_d = ix;    n2r_d = up;   d2_d = Half - dy;
      end else begin
        n1c_d = ix;    n1r_d = up;   d1_d = Half - dy;
        n2c_d = left;  n2r_d = iy;   d2_d = Half - dx;
      end
    end
  end

  assign wok_d = (op1_q == OP_WRITE) && (int'(col1_q) < int'(eff_w_i))
                 && (int'(row1_q) < int'(eff_h_i));
  assign ix_d  = (op1_q == OP_SAMPLE) ? ix : CW'(col1_q);
  assign iy_d  = (op1_q == OP_SAMPLE) ? iy : RW'(row1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opcode_o <= op1_q;
      wok_o    <= wok_d;
      ix_o     <= ix_d;
      iy_o     <= iy_d;
      n1c_o    <= n1c_d;
      n1r_o    <= n1r_d;
      n2c_o    <= n2c_d;
      n2r_o    <= n2r_d;
      d1_o     <= d1_d;
      d2_o     <= d2_d;
      colour_o <= colour1_q;
    end
  end

endmodule

@@ rtl/gst_texmem.sv @@
// ----------------------------------------------------------------------------
// gst_texmem
// Address stage and texture store: two copies give three reads per item.
// ----------------------------------------------------------------------------
module gst_texmem #(
  parameter int MAX_WIDTH       = 64,
  parameter int MAX_HEIGHT      = 64,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                    eff_w_i,
  input  logic                                              valid_i,
  input  logic                                              opcode_i,
  input  logic                                              wok_i,
  input  logic [((MAX_WIDTH>1)?$clog2(MAX_WIDTH):1)-1:0]    ix_i,
  input  logic [((MAX_HEIGHT>1)?$clog2(MAX_HEIGHT):1)-1:0]  iy_i,
  input  logic [((MAX_WIDTH>1)?$clog2(MAX_WIDTH):1)-1:0]    n1c_i,
  input  logic [((MAX_HEIGHT>1)?$clog2(MAX_HEIGHT):1)-1:0]  n1r_i,
  input  logic [((MAX_WIDTH>1)?$clog2(MAX_WIDTH):1)-1:0]    n2c_i,
  input  logic [((MAX_HEIGHT>1)?$clog2(MAX_HEIGHT):1)-1:0]  n2r_i,
  input  logic [COORD_FRAC_BITS-1:0]                        d1_i,
  input  logic [COORD_FRAC_BITS-1:0]                        d2_i,
  input  logic [gst_pkg::ColourWidth-1:0]                   colour_i,
  output logic                                              valid_o,
  output logic                                              opcode_o,
  output logic                                              wok_o,
  output logic [gst_pkg::ColourWidth-1:0]                   c0_o,
  output logic [gst_pkg::ColourWidth-1:0]                   c1_o,
  output logic [gst_pkg::ColourWidth-1:0]                   c2_o,
  output logic [COORD_FRAC_BITS-1:0]                        d1_o,
  output logic [COORD_FRAC_BITS-1:0]                        d2_o
);
  import gst_pkg::*;

  localparam int FB    = COORD_FRAC_BITS;
  localparam int EW    = $clog2(MAX_WIDTH+1);
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PW    = RW + EW + 1;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row,
                                            input logic [CW-1:0] col,
                                            input logic [EW-1:0] w);
    logic [PW-1:0] p;
    p = PW'(row) * PW'(w) + PW'(col);
    return AW'(p);
  endfunction

  logic [AW-1:0]          a0_q, a1_q, a2_q;
  logic                   v3_q, op3_q, wok3_q;
  logic [FB-1:0]          d13_q, d23_q;
  logic [ColourWidth-1:0] colour3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a0_q      <= addr_of(iy_i, ix_i, eff_w_i);
      a1_q      <= addr_of(n1r_i, n1c_i, eff_w_i);
      a2_q      <= addr_of(n2r_i, n2c_i, eff_w_i);
      op3_q     <= opcode_i;
      wok3_q    <= wok_i;
      d13_q     <= d1_i;
      d23_q     <= d2_i;
      colour3_q <= colour_i;
    end
  end

  logic [ColourWidth-1:0] mem_a [Depth];
  logic [ColourWidth-1:0] mem_b [Depth];
  logic                   we;

  assign we = en_i && v3_q && (op3_q == OP_WRITE) && wok3_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_a[a0_q] <= colour3_q;
    end
    if (en_i) begin
      c0_o <= mem_a[a0_q];
      c1_o <= mem_a[a1_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_b[a0_q] <= colour3_q;
    end
    if (en_i) begin
      c2_o <= mem_b[a2_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opcode_o <= op3_q;
      wok_o    <= wok3_q;
      d1_o     <= d13_q;
      d2_o     <= d23_q;
    end
  end

endmodule

@@ rtl/glyph_shaded_texel_sampler.sv @@
// ----------------------------------------------------------------------------
// glyph_shaded_texel_sampler
// Texture store with shaded two-colour sampling for glyph rendering.
// ----------------------------------------------------------------------------
// One item per cycle while the output is not stalled, through the stages from
// input to result register: scale, quadrant and neighbour select, address
// multiply, texture read, shade and colour pick. The texture is held twice so
// that the main texel and both neighbours are read in the same cycle; writes go
// to both copies in the read stage, so an item always sees every write accepted
// before it. The whole pipeline holds while a result waits at the output.
module glyph_shaded_texel_sampler #(
  parameter int MAX_WIDTH       = 64,
  parameter int MAX_HEIGHT      = 64,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [gst_pkg::CfgWidth-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               opcode_i,
  input  logic [COORD_FRAC_BITS:0]           x_coord_i,
  input  logic [COORD_FRAC_BITS:0]           y_coord_i,
  input  logic [gst_pkg::ReqColWidth-1:0]    texel_col_i,
  input  logic [gst_pkg::ReqColWidth-1:0]    texel_row_i,
  input  logic [gst_pkg::ColourWidth-1:0]    write_colour_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [gst_pkg::AttrWidth-1:0]      attribute_o,
  output logic [gst_pkg::ShadeWidth-1:0]     glyph_shade_o,
  output logic                               write_ok_o
);
  import gst_pkg::*;

  localparam int FB = COORD_FRAC_BITS;
  localparam int EW = $clog2(MAX_WIDTH+1);
  localparam int EH = $clog2(MAX_HEIGHT+1);
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SW = FB + 6;

  logic [CfgWidth-1:0] cfg_w_q, cfg_h_q;
  logic [EW-1:0]       eff_w;
  logic [EH-1:0]       eff_h;
  logic                en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CfgWidth'(CfgReset);
      cfg_h_q <= CfgWidth'(CfgReset);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_TEX_WIDTH) begin
        cfg_w_q <= cfg_data_i;
      end else begin
        cfg_h_q <= cfg_data_i;
      end
    end
  end

  assign eff_w = (cfg_w_q == '0) ? EW'(1) :
                 (int'(cfg_w_q) > MAX_WIDTH) ? EW'(MAX_WIDTH) : EW'(cfg_w_q);
  assign eff_h = (cfg_h_q == '0) ? EH'(1) :
                 (int'(cfg_h_q) > MAX_HEIGHT) ? EH'(MAX_HEIGHT) : EH'(cfg_h_q);

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic                   v2, op2, wok2;
  logic [CW-1:0]          ix2, n1c2, n2c2;
  logic [RW-1:0]          iy2, n1r2, n2r2;
  logic [FB-1:0]          d12, d22;
  logic [ColourWidth-1:0] colour2;

  gst_coord #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_coord (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .eff_w_i        (eff_w),
    .eff_h_i        (eff_h),
    .valid_i        (in_valid_i),
    .opcode_i       (opcode_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .texel_col_i    (texel_col_i),
    .texel_row_i    (texel_row_i),
    .write_colour_i (write_colour_i),
    .valid_o        (v2),
    .opcode_o       (op2),
    .wok_o          (wok2),
    .ix_o           (ix2),
    .iy_o           (iy2),
    .n1c_o          (n1c2),
    .n1r_o          (n1r2),
    .n2c_o          (n2c2),
    .n2r_o          (n2r2),
    .d1_o           (d12),
    .d2_o           (d22),
    .colour_o       (colour2)
  );

  logic                   v4, op4, wok4;
  logic [ColourWidth-1:0] c0, c1, c2;
  logic [FB-1:0]          d14, d24;

  gst_texmem #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_texmem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .eff_w_i  (eff_w),
    .valid_i  (v2),
    .opcode_i (op2),
    .wok_i    (wok2),
    .ix_i     (ix2),
    .iy_i     (iy2),
    .n1c_i    (n1c2),
    .n1r_i    (n1r2),
    .n2c_i    (n2c2),
    .n2r_i    (n2r2),
    .d1_i     (d12),
    .d2_i     (d22),
    .colour_i (colour2),
    .valid_o  (v4),
    .opcode_o (op4),
    .wok_o    (wok4),
    .c0_o     (c0),
    .c1_o     (c1),
    .c2_o     (c2),
    .d1_o     (d14),
    .d2_o     (d24)
  );

  logic                   same;
  logic [ColourWidth-1:0] csec;
  logic [FB-1:0]          dsel;
  logic [SW-1:0]          da, db;
  shade_e                 shade;
  logic [AttrWidth-1:0]   attr_d;

  assign same   = (c1 == c0);
  assign csec   = same ? c2 : c1;
  assign dsel   = same ? d24 : d14;
  assign da     = SW'(dsel) * SW'(ShadeMulA);
  assign db     = SW'(dsel) * SW'(ShadeMulB);
  assign attr_d = {csec, 4'b0000} | {4'b0000, c0};

  always_comb begin
    if (da < (SW'(ShadeRefA) << FB)) begin
      shade = SHADE_SOLID;
    end else if (db < (SW'(ShadeRefB) << FB)) begin
      shade = SHADE_3Q;
    end else begin
      shade = SHADE_HALF;
    end
  end

  logic                  out_valid_q, wok_q;
  logic [AttrWidth-1:0]  attr_q;
  logic [ShadeWidth-1:0] shade_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (op4 == OP_SAMPLE) begin
        attr_q  <= attr_d;
        shade_q <= shade;
        wok_q   <= 1'b0;
      end else begin
        attr_q  <= '0;
        shade_q <= SHADE_SOLID;
        wok_q   <= wok4;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign attribute_o   = attr_q;
  assign glyph_shade_o = shade_q;
  assign write_ok_o    = wok_q;

`include "glyph_shaded_texel_sampler_assert.svh"

  `GST_ASSERT_IMP(a_write_blank, out_valid_o && write_ok_o,
                  attribute_o == '0 && glyph_shade_o == SHADE_SOLID,
                  "write item carries sample data")
  `GST_ASSERT_IMP(a_shade_code, out_valid_o,
                  glyph_shade_o != 2'd3, "shade code out of range")
  `GST_ASSERT_NXT(a_stall_hold, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(attribute_o) && !$past(in_ready_o),
                  "stalled pipeline moved")

endmodule

@@ dv/glyph_shaded_texel_sampler_test.sv @@
// ----------------------------------------------------------------------------
// Glyph shaded texel sampler testbench
// Drives directed, then random writes and samples through the valid/ready ports,
// then fills texel regions under several texture sizes, each followed by random
// items, with idle gaps on both sides. Results are checked against an in-bench
// model of the texture, the quadrant walk and the shade thresholds, or typed rows.
// ----------------------------------------------------------------------------
module glyph_shaded_texel_sampler_test;
  import gst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits  = 16;
  localparam int MaxW      = 64;
  localparam int MaxH      = 64;
  localparam int TexDepth  = MaxW * MaxH;
  localparam longint One   = 64'd1 << FracBits;
  localparam longint Half  = One >> 1;
  localparam int IdleLimit = 5000;

  typedef struct packed {
    logic [AttrWidth-1:0]  attr;
    logic [ShadeWidth-1:0] shade;
    logic                  ok;
  } texel_result_t;

  typedef struct {
    op_e                     op;
    logic [FracBits:0]       x;
    logic [FracBits:0]       y;
    logic [ReqColWidth-1:0]  col;
    logic [ReqColWidth-1:0]  row;
    logic [ColourWidth-1:0]  colour;
    bit                      typed;
    texel_result_t           res;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_index_i = REG_TEX_WIDTH;
  logic [CfgWidth-1:0]    cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   opcode_i = OP_WRITE;
  logic [FracBits:0]      x_coord_i = '0;
  logic [FracBits:0]      y_coord_i = '0;
  logic [ReqColWidth-1:0] texel_col_i = '0;
  logic [ReqColWidth-1:0] texel_row_i = '0;
  logic [ColourWidth-1:0] write_colour_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [AttrWidth-1:0]   attribute_o;
  logic [ShadeWidth-1:0]  glyph_shade_o;
  logic                   write_ok_o;

  glyph_shaded_texel_sampler dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [ColourWidth-1:0] texel_mem [TexDepth];
  bit                     texel_known [TexDepth];
  logic [CfgWidth-1:0]    tex_w_reg = CfgWidth'(CfgReset);
  logic [CfgWidth-1:0]    tex_h_reg = CfgWidth'(CfgReset);

  texel_result_t pending_results [$];
  int fail_count = 0;
  int result_count = 0;
  int sample_count = 0;
  int write_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  function automatic int unsigned eff_size(logic [CfgWidth-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic void locate(input logic [FracBits:0] xc, input logic [FracBits:0] yc,
                                 output int unsigned c0i, output int unsigned n1i,
                                 output int unsigned n2i, output longint d1,
                                 output longint d2);
    int unsigned w, h, ix, iy, rt, lf, dn, up, n1c, n1r, n2c, n2r;
    longint x, y, fx, fy, dx, dy;
    w = eff_size(tex_w_reg, MaxW);
    h = eff_size(tex_h_reg, MaxH);
    x = (xc > One) ? One : xc;
    y = (yc > One) ? One : yc;
    fx = x * w;
    fy = y * h;
    ix = (fx >> FracBits) % w;
    iy = (fy >> FracBits) % h;
    dx = fx & (One - 1);
    dy = fy & (One - 1);
    rt = (ix + 1) % w;
    lf = (ix + w - 1) % w;
    dn = (iy + 1) % h;
    up = (iy + h - 1) % h;
    if (dx >= Half && dy >= Half) begin
      if (dx > dy) begin
        n1c = rt; n1r = iy; d1 = dx - Half; n2c = ix; n2r = dn; d2 = dy - Half;
      end else begin
        n1c = ix; n1r = dn; d1 = dy - Half; n2c = rt; n2r = iy; d2 = dx - Half;
      end
    end else if (dx >= Half && dy <= Half) begin
      if (One - dx < dy) begin
        n1c = rt; n1r = iy; d1 = dx - Half; n2c = ix; n2r = up; d2 = Half - dy;
      end else begin
        n1c = ix; n1r = up; d1 = Half - dy; n2c = rt; n2r = iy; d2 = dx - Half;
      end
    end else if (dx <= Half && dy >= Half) begin
      if (dx < One - dy) begin
        n1c = lf; n1r = iy; d1 = Half - dx; n2c = ix; n2r = dn; d2 = dy - Half;
      end else begin
        n1c = ix; n1r = dn; d1 = dy - Half; n2c = lf; n2r = iy; d2 = Half - dx;
      end
    end else begin
      if (dx < dy) begin
        n1c = lf; n1r = iy; d1 = Half - dx; n2c = ix; n2r = up; d2 = Half - dy;
      end else begin
        n1c = ix; n1r = up; d1 = Half - dy; n2c = lf; n2r = iy; d2 = Half - dx;
      end
    end
    c0i = iy * w + ix;
    n1i = n1r * w + n1c;
    n2i = n2r * w + n2c;
  endfunction

  function automatic bit sample_is_safe(logic [FracBits:0] xc, logic [FracBits:0] yc);
    int unsigned a, b, c;
    longint d1, d2;
    locate(xc, yc, a, b, c, d1, d2);
    return texel_known[a] && texel_known[b] && texel_known[c];
  endfunction

  function automatic texel_result_t shade_texel(op_e op, logic [FracBits:0] xc,
                                                logic [FracBits:0] yc,
                                                logic [ReqColWidth-1:0] col,
                                                logic [ReqColWidth-1:0] row,
                                                logic [ColourWidth-1:0] colour);
    texel_result_t r;
    int unsigned w, h, c0i, n1i, n2i;
    longint d1, d2;
    logic [ColourWidth-1:0] c0, c1;
    r = '0;
    w = eff_size(tex_w_reg, MaxW);
    h = eff_size(tex_h_reg, MaxH);
    if (op == OP_WRITE) begin
      if (col < w && row < h) begin
        texel_mem[row * w + col] = colour;
        texel_known[row * w + col] = 1;
        r.ok = 1'b1;
      end
      return r;
    end
    locate(xc, yc, c0i, n1i, n2i, d1, d2);
    c0 = texel_mem[c0i];
    c1 = texel_mem[n1i];
    if (c1 == c0) begin
      c1 = texel_mem[n2i];
      d1 = d2;
    end
    r.attr = AttrWidth'({4'h0, c0} | ({4'h0, c1} << 4));
    if (d1 * ShadeMulA < One * ShadeRefA) r.shade = SHADE_SOLID;
    else if (d1 * ShadeMulB < One * ShadeRefB) r.shade = SHADE_3Q;
    else r.shade = SHADE_HALF;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    texel_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", attribute_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (attribute_o !== want.attr) report_mismatch("attribute", attribute_o, want.attr);
        if (glyph_shade_o !== want.shade) report_mismatch("shade", glyph_shade_o, want.shade);
        if (write_ok_o !== want.ok) report_mismatch("write_ok", write_ok_o, want.ok);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_cnt = 80;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no item moved for %0d cycles", IdleLimit);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // push one item and leave valid high for a back-to-back follower
  task automatic send_texel_op(op_e op, logic [FracBits:0] xc, logic [FracBits:0] yc,
                               logic [ReqColWidth-1:0] col, logic [ReqColWidth-1:0] row,
                               logic [ColourWidth-1:0] colour, bit typed = 0,
                               texel_result_t typed_res = '0);
    texel_result_t r;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    x_coord_i <= xc;
    y_coord_i <= yc;
    texel_col_i <= col;
    texel_row_i <= row;
    write_colour_i <= colour;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    r = shade_texel(op, xc, yc, col, row, colour);
    pending_results.push_back(typed ? typed_res : r);
    if (op == OP_SAMPLE) sample_count++;
    else write_count++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_size(logic [CfgWidth-1:0] w, logic [CfgWidth-1:0] h);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_TEX_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_index_i <= REG_TEX_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tex_w_reg = w;
    tex_h_reg = h;
  endtask

  task automatic fill_region;
    int unsigned w, h;
    w = eff_size(tex_w_reg, MaxW);
    h = eff_size(tex_h_reg, MaxH);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (!texel_known[r * w + c]) begin
          send_texel_op(OP_WRITE, '0, '0, ReqColWidth'(c), ReqColWidth'(r),
                        ColourWidth'($urandom));
        end
      end
    end
  endtask

  function automatic logic [FracBits:0] rand_coord;
    case ($urandom_range(9))
      0: return '0;
      1: return (FracBits+1)'(One);
      2: return (FracBits+1)'($urandom_range(2 * One - 1, One));
      default: return (FracBits+1)'($urandom_range(One, 0));
    endcase
  endfunction

  task automatic random_phase(int n_items);
    int unsigned w, h;
    logic [FracBits:0] xc, yc;
    w = eff_size(tex_w_reg, MaxW);
    h = eff_size(tex_h_reg, MaxH);
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 3) hold_req = 1;
      if (i == 2 * n_items / 3) drain();
      xc = rand_coord();
      yc = rand_coord();
      if ($urandom_range(99) < 65 && sample_is_safe(xc, yc)) begin
        send_texel_op(OP_SAMPLE, xc, yc, ReqColWidth'($urandom), ReqColWidth'($urandom),
                      ColourWidth'($urandom));
      end else if ($urandom_range(9) == 0) begin
        send_texel_op(OP_WRITE, xc, yc, ReqColWidth'($urandom), ReqColWidth'($urandom),
                      ColourWidth'($urandom));
      end else begin
        send_texel_op(OP_WRITE, xc, yc, ReqColWidth'($urandom_range(w - 1)),
                      ReqColWidth'($urandom_range(h - 1)), ColourWidth'($urandom));
      end
    end
  endtask

  stim_row_t directed [] = '{
    '{OP_WRITE,  '0, '0, 7'd0,   7'd0,   8'h13, 1, '{12'h0, SHADE_SOLID, 1'b1}},
    '{OP_WRITE,  '0, '0, 7'd1,   7'd0,   8'h24, 1, '{12'h0, SHADE_SOLID, 1'b1}},
    '{OP_WRITE,  '0, '0, 7'd0,   7'd1,   8'h35, 1, '{12'h0, SHADE_SOLID, 1'b1}},
    '{OP_WRITE,  '0, '0, 7'd1,   7'd1,   8'hFF, 1, '{12'h0, SHADE_SOLID, 1'b1}},
    '{OP_WRITE,  '0, '0, 7'd127, 7'd0,   8'h00, 1, '{12'h0, SHADE_SOLID, 1'b0}},
    '{OP_WRITE,  '0, '0, 7'd0,   7'd127, 8'h55, 1, '{12'h0, SHADE_SOLID, 1'b0}},
    '{OP_WRITE,  '0, '0, 7'd2,   7'd1,   8'hAA, 1, '{12'h0, SHADE_SOLID, 1'b0}},
    '{OP_SAMPLE, '0, '0, 7'd0,   7'd0,   8'h00, 1, '{12'h353, SHADE_HALF, 1'b0}},
    '{OP_SAMPLE, 17'h10000, 17'h10000, 7'd0, 7'd0, 8'h00, 0, '0},
    '{OP_SAMPLE, 17'h1FFFF, 17'h1FFFF, 7'd0, 7'd0, 8'h00, 0, '0},
    '{OP_SAMPLE, 17'h04000, 17'h04000, 7'd0, 7'd0, 8'h00, 0, '0},
    '{OP_SAMPLE, 17'h0C000, 17'h04000, 7'd0, 7'd0, 8'h00, 0, '0},
    '{OP_SAMPLE, 17'h04000, 17'h0C000, 7'd0, 7'd0, 8'h00, 0, '0},
    '{OP_SAMPLE, 17'h0FFFF, 17'h08000, 7'd0, 7'd0, 8'h00, 0, '0},
    '{OP_SAMPLE, 17'h02000, 17'h05000, 7'd0, 7'd0, 8'h00, 0, '0},
    '{OP_WRITE,  '0, '0, 7'd1,   7'd0,   8'h13, 1, '{12'h0, SHADE_SOLID, 1'b1}},
    '{OP_SAMPLE, 17'h06000, 17'h02000, 7'd0, 7'd0, 8'h00, 0, '0},
    '{OP_SAMPLE, 17'h07000, 17'h0E000, 7'd0, 7'd0, 8'h00, 0, '0},
    '{OP_SAMPLE, 17'h0A000, 17'h0D000, 7'd0, 7'd0, 8'h00, 0, '0}
  };

  initial begin
    logic [CfgWidth-1:0] size_list [7][2] = '{
      '{7'd0, 7'd0}, '{7'd127, 7'd1}, '{7'd1, 7'd64}, '{7'd8, 7'd8},
      '{7'd5, 7'd7}, '{7'd16, 7'd16}, '{7'd64, 7'd1}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gap_pct = 6;
    recv_stall_pct = 69;
    set_size(7'd2, 7'd2);
    foreach (directed[i]) begin
      send_texel_op(directed[i].op, directed[i].x, directed[i].y, directed[i].col,
                    directed[i].row, directed[i].colour, directed[i].typed,
                    directed[i].res);
    end
    random_phase(60);
    for (int p = 0; p < 7; p++) begin
      if (p == 3) begin
        send_gap_pct = 69;
        recv_stall_pct = 6;
      end else if (p == 5) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      set_size(size_list[p][0], size_list[p][1]);
      fill_region();
      random_phase(75);
    end
    drain();
    $display("covered %0d writes and %0d samples over 8 texture sizes, %0d results checked",
             write_count, sample_count, result_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
